### hw/rtl/erm_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rotation matrix block.
`default_nettype none
package erm_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int Q30_SHIFT    = 30;

    // CORDIC gain 0.60725293500888 in Q30
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef logic signed [16:0] t_angle;
    typedef logic signed [31:0] t_q30;

    // atan(2^-i) in degrees times 2^23
    function automatic t_q30 atan_q23(input int idx);
        t_q30 res;
        res = 32'sd0;
        unique case (idx)
            0:  res = 32'sd377487360;
            1:  res = 32'sd222843801;
            2:  res = 32'sd117744544;
            3:  res = 32'sd59768969;
            4:  res = 32'sd30000467;
            5:  res = 32'sd15014858;
            6:  res = 32'sd7509261;
            7:  res = 32'sd3754860;
            8:  res = 32'sd1877459;
            9:  res = 32'sd938733;
            10: res = 32'sd469367;
            11: res = 32'sd234683;
            12: res = 32'sd117342;
            13: res = 32'sd58671;
            14: res = 32'sd29335;
            15: res = 32'sd14668;
            16: res = 32'sd7334;
            17: res = 32'sd3667;
            18: res = 32'sd1833;
            19: res = 32'sd917;
            20: res = 32'sd458;
            21: res = 32'sd229;
            22: res = 32'sd115;
            23: res = 32'sd57;
            default: res = 32'sd0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ellipsoid_rotation_matrix.sv
// Top level: Z-Y-X Euler angles to the three column direction vectors of the rotation matrix.
// Each angle triple (signed degrees times 128, any 17-bit value, wrapped modulo 360) gives one
// matrix, Rz(azimuth)*Ry(-dip)*Rx(roll), whose columns leave as dir1, dir2 and dir3 in signed
// fixed point with FRAC_BITS fraction bits, clamped to [-1,1]. A new triple is taken every
// cycle when not stalled; the pipeline is the angle reduction stage, the 24 CORDIC stages,
// the sign stage and five stages of multiply, round and combine. A stall on the output freezes
// the whole pipeline, so o_stall is high exactly while a result waits and i_stall is high.
`default_nettype none
module ellipsoid_rotation_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire erm_pkg::t_angle             i_azimuth_deg,
    input  wire erm_pkg::t_angle             i_dip_deg,
    input  wire erm_pkg::t_angle             i_roll_deg,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [FRAC_BITS+1:0]      o_dir1_x,
    output logic signed [FRAC_BITS+1:0]      o_dir1_y,
    output logic signed [FRAC_BITS+1:0]      o_dir1_z,
    output logic signed [FRAC_BITS+1:0]      o_dir2_x,
    output logic signed [FRAC_BITS+1:0]      o_dir2_y,
    output logic signed [FRAC_BITS+1:0]      o_dir2_z,
    output logic signed [FRAC_BITS+1:0]      o_dir3_x,
    output logic signed [FRAC_BITS+1:0]      o_dir3_y,
    output logic signed [FRAC_BITS+1:0]      o_dir3_z
);
    import erm_pkg::*;

    localparam int OW       = FRAC_BITS + 2;
    localparam int DROP     = Q30_SHIFT - FRAC_BITS;
    localparam int N_STAGES = CORDIC_STEPS + 7;

    logic w_en;
    logic [N_STAGES-1:0] r_vld;

    t_q30 w_sa, w_ca, w_sd, w_cd, w_sr, w_cr;

    // raw products and forwarded terms
    logic signed [63:0] r_raw [10];
    t_q30 r1_sd, r1_sr, r1_cr;
    t_q30 r2_rnd [10];
    t_q30 r2_sd, r2_sr, r2_cr;
    logic signed [63:0] r3_raw [4];
    t_q30 r3_fw [8];
    // ca*sr rides alongside the triple products
    t_q30 r2_casr_fw;
    logic signed [32:0] r_m [9];
    logic signed [OW-1:0] r_out [9];

    function automatic t_q30 rnd_q30(input logic signed [63:0] v);
        logic signed [63:0] sum;
        sum = v + 64'sd536870912;
        return sum[61:30];
    endfunction

    function automatic logic signed [OW-1:0] to_out(input logic signed [32:0] v);
        logic signed [35:0] sum;
        logic signed [35:0] sh;
        logic signed [35:0] one;
        one = 36'sd1 <<< FRAC_BITS;
        sum = 36'(v);
        if (DROP > 0) begin
            sum = sum + (36'sd1 <<< (DROP - 1));
        end
        sh = sum >>> DROP;
        if (sh > one) begin
            sh = one;
        end else if (sh < -one) begin
            sh = -one;
        end
        return sh[OW-1:0];
    endfunction

    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;
    assign o_valid = r_vld[N_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STAGES-2:0], i_valid};
        end
    end

    erm_sincos u_az (.i_clk, .i_en(w_en), .i_ang(i_azimuth_deg), .o_sin(w_sa), .o_cos(w_ca));
    erm_sincos u_dp (.i_clk, .i_en(w_en), .i_ang(i_dip_deg),     .o_sin(w_sd), .o_cos(w_cd));
    erm_sincos u_rl (.i_clk, .i_en(w_en), .i_ang(i_roll_deg),    .o_sin(w_sr), .o_cos(w_cr));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // pair products
            r_raw[0] <= 64'(w_ca) * 64'(w_sd);
            r_raw[1] <= 64'(w_sa) * 64'(w_sd);
            r_raw[2] <= 64'(w_ca) * 64'(w_cd);
            r_raw[3] <= 64'(w_sa) * 64'(w_cd);
            r_raw[4] <= 64'(w_cd) * 64'(w_sr);
            r_raw[5] <= 64'(w_cd) * 64'(w_cr);
            r_raw[6] <= 64'(w_sa) * 64'(w_cr);
            r_raw[7] <= 64'(w_sa) * 64'(w_sr);
            r_raw[8] <= 64'(w_ca) * 64'(w_cr);
            r_raw[9] <= 64'(w_ca) * 64'(w_sr);
            r1_sd <= w_sd;
            r1_sr <= w_sr;
            r1_cr <= w_cr;
            // round to Q30
            for (int k = 0; k < 10; k++) begin
                r2_rnd[k] <= rnd_q30(r_raw[k]);
            end
            r2_sd <= r1_sd;
            r2_sr <= r1_sr;
            r2_cr <= r1_cr;
            // triple products from the rounded p and q
            r3_raw[0] <= 64'(r2_rnd[0]) * 64'(r2_sr);
            r3_raw[1] <= 64'(r2_rnd[1]) * 64'(r2_sr);
            r3_raw[2] <= 64'(r2_rnd[0]) * 64'(r2_cr);
            r3_raw[3] <= 64'(r2_rnd[1]) * 64'(r2_cr);
            r3_fw[0] <= r2_rnd[2];
            r3_fw[1] <= r2_rnd[3];
            r3_fw[2] <= r2_sd;
            r3_fw[3] <= r2_rnd[4];
            r3_fw[4] <= r2_rnd[5];
            r3_fw[5] <= r2_rnd[6];
            r3_fw[6] <= r2_rnd[7];
            r3_fw[7] <= r2_rnd[8];
            // matrix entries, Q30
            r_m[0] <= 33'(r3_fw[0]);
            r_m[1] <= 33'(r3_fw[1]);
            r_m[2] <= 33'(r3_fw[2]);
            r_m[3] <= -33'(r3_fw[5]) - 33'(rnd_q30(r3_raw[0]));
            r_m[4] <=  33'(r3_fw[7]) - 33'(rnd_q30(r3_raw[1]));
            r_m[5] <= 33'(r3_fw[3]);
            r_m[6] <=  33'(r3_fw[6]) - 33'(rnd_q30(r3_raw[2]));
            r_m[7] <= -33'(r2_casr_fw) - 33'(rnd_q30(r3_raw[3]));
            r_m[8] <= 33'(r3_fw[4]);
            for (int k = 0; k < 9; k++) begin
                r_out[k] <= to_out(r_m[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_casr_fw <= r2_rnd[9];
        end
    end

    assign o_dir1_x = r_out[0];
    assign o_dir1_y = r_out[1];
    assign o_dir1_z = r_out[2];
    assign o_dir2_x = r_out[3];
    assign o_dir2_y = r_out[4];
    assign o_dir2_z = r_out[5];
    assign o_dir3_x = r_out[6];
    assign o_dir3_y = r_out[7];
    assign o_dir3_z = r_out[8];

`ifndef SYNTHESIS
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result waiting");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[N_STAGES-2] && !o_stall) |=> o_valid)
        else $error("result lost at the last stage");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir1_x <= (OW'(1) <<< FRAC_BITS)) && (o_dir1_x >= -(OW'(1) <<< FRAC_BITS))
            && (o_dir3_z <= (OW'(1) <<< FRAC_BITS)) && (o_dir3_z >= -(OW'(1) <<< FRAC_BITS)))
        else $error("direction entry outside [-1,1]");
`endif

endmodule
`default_nettype wire

### hw/rtl/erm_sincos.sv
// Pipelined sine and cosine of one angle: reduction, 24 CORDIC stages, sign fix.
`default_nettype none
module erm_sincos (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire erm_pkg::t_angle i_ang,
    output erm_pkg::t_q30       o_sin,
    output erm_pkg::t_q30       o_cos
);
    import erm_pkg::*;

    logic signed [17:0] n_red;
    logic               n_neg;
    logic signed [17:0] w_wrap;

    t_q30 r_x   [CORDIC_STEPS+1];
    t_q30 r_y   [CORDIC_STEPS+1];
    t_q30 r_z   [CORDIC_STEPS+1];
    logic r_neg [CORDIC_STEPS+1];
    t_q30 r_sin;
    t_q30 r_cos;

    // wrap into [-180,180), then fold beyond +-90 onto the other half
    always_comb begin
        w_wrap = {i_ang[16], i_ang};
        if (w_wrap >= 18'(HALF_TURN)) begin
            w_wrap = w_wrap - 18'(FULL_TURN);
        end else if (w_wrap < -18'(HALF_TURN)) begin
            w_wrap = w_wrap + 18'(FULL_TURN);
        end
        n_red = w_wrap;
        n_neg = 1'b0;
        if (w_wrap > 18'(QUARTER_TURN)) begin
            n_red = w_wrap - 18'(HALF_TURN);
            n_neg = 1'b1;
        end else if (w_wrap < -18'(QUARTER_TURN)) begin
            n_red = w_wrap + 18'(HALF_TURN);
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= {n_red[15:0], 16'h0000};
            r_neg[0] <= n_neg;
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[gi] >= 0) begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] - atan_q23(gi);
                end else begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] + atan_q23(gi);
                end
                r_neg[gi+1] <= r_neg[gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
            r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire
